>>> sv/opte_pkg.sv
// Package for the sprite part tile expander.
// Holds the microcode ROM, control and status structs, and the size table.
// No dependencies.
package opte_pkg;

    // Field widths
    localparam int AttrW   = 16;
    localparam int PosW    = 10;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 9;
    localparam int CntW    = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DETAIL   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_X_ORIGIN = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_Y_ORIGIN = 2'd2;

    // Shape code that yields a single empty result
    localparam logic [1:0] SHAPE_EMPTY = 2'd3;

    // Microprogram step addresses
    typedef logic [1:0] t_step;
    localparam t_step STEP_WAIT   = 2'd0;
    localparam t_step STEP_DECODE = 2'd1;
    localparam t_step STEP_EMIT   = 2'd2;
    localparam t_step STEP_EMPTY  = 2'd3;

    // Branch conditions
    typedef enum logic [1:0] {
        COND_IN_XFER   = 2'd0,
        COND_SHAPE3    = 2'd1,
        COND_EMIT_LAST = 2'd2,
        COND_OUT_FREE  = 2'd3
    } t_cond;

    // Datapath controls from the current microword
    typedef struct packed {
        logic in_ready;
        logic load;
        logic decode;
        logic emit;
        logic empty;
    } t_ctrl;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic shape3;
        logic last_tile;
        logic out_free;
    } t_status;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_step jump_true;
        t_step jump_false;
    } t_uword;

    // Microcode ROM
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '0;
        unique case (step)
            STEP_WAIT: begin
                w.ctrl.in_ready = 1'b1;
                w.ctrl.load     = 1'b1;
                w.cond          = COND_IN_XFER;
                w.jump_true     = STEP_DECODE;
                w.jump_false    = STEP_WAIT;
            end
            STEP_DECODE: begin
                w.ctrl.decode = 1'b1;
                w.cond        = COND_SHAPE3;
                w.jump_true   = STEP_EMPTY;
                w.jump_false  = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_EMIT_LAST;
                w.jump_true = STEP_WAIT;
                w.jump_false = STEP_EMIT;
            end
            STEP_EMPTY: begin
                w.ctrl.empty = 1'b1;
                w.cond       = COND_OUT_FREE;
                w.jump_true  = STEP_WAIT;
                w.jump_false = STEP_EMPTY;
            end
        endcase
        return w;
    endfunction

    // Tile columns minus one, by shape and size
    function automatic logic [CntW-1:0] cols_m1(input logic [1:0] shape,
                                                input logic [1:0] size);
        logic [CntW-1:0] c;
        c = '0;
        unique case ({shape, size})
            4'b0000: c = 3'd0;
            4'b0001: c = 3'd1;
            4'b0010: c = 3'd3;
            4'b0011: c = 3'd7;
            4'b0100: c = 3'd1;
            4'b0101: c = 3'd3;
            4'b0110: c = 3'd3;
            4'b0111: c = 3'd7;
            4'b1000: c = 3'd0;
            4'b1001: c = 3'd0;
            4'b1010: c = 3'd1;
            4'b1011: c = 3'd3;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // Tile rows minus one, by shape and size
    function automatic logic [CntW-1:0] rows_m1(input logic [1:0] shape,
                                                input logic [1:0] size);
        logic [CntW-1:0] r;
        r = '0;
        unique case ({shape, size})
            4'b0000: r = 3'd0;
            4'b0001: r = 3'd1;
            4'b0010: r = 3'd3;
            4'b0011: r = 3'd7;
            4'b0100: r = 3'd0;
            4'b0101: r = 3'd0;
            4'b0110: r = 3'd1;
            4'b0111: r = 3'd3;
            4'b1000: r = 3'd1;
            4'b1001: r = 3'd3;
            4'b1010: r = 3'd3;
            4'b1011: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/oam_part_tile_expander_unit.sv
// Sprite part tile expander, top level.
// After an input transfer the part is registered by the decode step, then each result by the output reg.
// Throughput: a new part is taken only after the last one is done (64 tiles for 64x64);
//   one tile per cycle while the output is not stalled, set by the single emit step; an empty part gives one result.
// Reset: synchronous active low; clears the step counter, output valid
//   and the config registers (detail, x origin and y origin to zero).
module oam_part_tile_expander_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [opte_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [opte_pkg::CfgDatW-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [opte_pkg::AttrW-1:0]       i_attr_zero,
    input  logic [opte_pkg::AttrW-1:0]       i_attr_one,
    input  logic [opte_pkg::AttrW-1:0]       i_attr_two,
    input  logic                             i_final_part,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [opte_pkg::PosW-1:0] o_pos_x,
    output logic signed [opte_pkg::PosW-1:0] o_pos_y,
    output logic [opte_pkg::AttrW-1:0]       o_tile_number,
    output logic                             o_tile_valid,
    output logic                             o_part_end,
    output logic                             o_frame_end
);
    import opte_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_ctrl.in_ready;

    opte_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    opte_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_attr_zero   (i_attr_zero),
        .i_attr_one    (i_attr_one),
        .i_attr_two    (i_attr_two),
        .i_final_part  (i_final_part),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_tile_number (o_tile_number),
        .o_tile_valid  (o_tile_valid),
        .o_part_end    (o_part_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

>>> sv/opte_sequencer.sv
// Microcode sequencer: step counter, control ROM and branch logic.
// Depends on opte_pkg.
module opte_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  opte_pkg::t_status i_status,
    output opte_pkg::t_ctrl  o_ctrl
);
    import opte_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_cond;

    // Fetch the current microword
    assign w_word = ucode_rom(r_step);
    assign o_ctrl = w_word.ctrl;

    // Evaluate the branch condition
    always_comb begin
        unique case (w_word.cond)
            COND_IN_XFER:   w_cond = i_in_valid;
            COND_SHAPE3:    w_cond = i_status.shape3;
            COND_EMIT_LAST: w_cond = i_status.out_free & i_status.last_tile;
            COND_OUT_FREE:  w_cond = i_status.out_free;
            default:        w_cond = 1'b0;
        endcase
        n_step = w_cond ? w_word.jump_true : w_word.jump_false;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> sv/opte_datapath.sv
// Datapath: config registers, attribute decode, tile counters, output register.
// Depends on opte_pkg.
module opte_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  opte_pkg::t_ctrl                i_ctrl,
    output opte_pkg::t_status              o_status,
    input  logic                           i_cfg_we,
    input  logic [opte_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [opte_pkg::CfgDatW-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [opte_pkg::AttrW-1:0]     i_attr_zero,
    input  logic [opte_pkg::AttrW-1:0]     i_attr_one,
    input  logic [opte_pkg::AttrW-1:0]     i_attr_two,
    input  logic                           i_final_part,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic signed [opte_pkg::PosW-1:0] o_pos_x,
    output logic signed [opte_pkg::PosW-1:0] o_pos_y,
    output logic [opte_pkg::AttrW-1:0]     o_tile_number,
    output logic                           o_tile_valid,
    output logic                           o_part_end,
    output logic                           o_frame_end
);
    import opte_pkg::*;

    // Config registers
    logic [3:0]  r_detail;
    logic [8:0]  r_x_origin;
    logic [7:0]  r_y_origin;

    // Captured attributes
    logic [AttrW-1:0] r_a0, r_a1, r_a2;
    logic             r_final;

    // Decoded part
    logic [PosW-1:0]  r_base_x, r_base_y;
    logic [AttrW-1:0] r_tile_base;
    logic [CntW-1:0]  r_cols_m1, r_rows_m1, r_xm, r_ym;
    logic [CntW-1:0]  r_tx, r_ty;

    // Output register
    logic             r_out_valid;
    logic [PosW-1:0]  r_pos_x, r_pos_y;
    logic [AttrW-1:0] r_tile;
    logic             r_tvalid, r_pend, r_fend;

    logic             w_out_free, w_last, w_fire, w_efire;
    logic [10:0]      w_sum_x;
    logic [PosW-1:0]  w_base_x, w_base_y;
    logic [3:0]       w_pal;
    logic [9:0]       w_idx;
    logic [AttrW-1:0] w_flags;
    logic [CntW-1:0]  w_col, w_row;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = (r_tx == r_cols_m1) && (r_ty == r_rows_m1);
    assign w_fire     = i_ctrl.emit && w_out_free;
    assign w_efire    = i_ctrl.empty && w_out_free;

    assign o_status.shape3    = (r_a0[15:14] == SHAPE_EMPTY);
    assign o_status.last_tile = w_last;
    assign o_status.out_free  = w_out_free;

    // Decode: origin shift, sign fix, x wrap, palette and tile offsets
    always_comb begin
        w_sum_x = {2'b00, r_x_origin} + {{2{r_a1[8]}}, r_a1[8:0]};
        if ($signed(w_sum_x) > 11'sd255) begin
            w_sum_x = w_sum_x - 11'd255;
        end
        w_base_x = w_sum_x[PosW-1:0];
        w_base_y = {2'b00, r_y_origin} + {{2{r_a0[7]}}, r_a0[7:0]};
        w_pal    = r_a2[15:12] + r_detail;
        w_idx    = r_a2[9:0] + {r_detail, 6'b0};
        w_flags  = {4'b0, r_a1[13], r_a1[12], 10'b0};
    end

    assign w_col = r_tx ^ r_xm;
    assign w_row = r_ty ^ r_ym;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detail   <= '0;
            r_x_origin <= '0;
            r_y_origin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DETAIL:   r_detail   <= i_cfg_data[3:0];
                CFG_X_ORIGIN: r_x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Attribute capture, decode and tile walk
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && i_in_valid) begin
            r_a0    <= i_attr_zero;
            r_a1    <= i_attr_one;
            r_a2    <= i_attr_two;
            r_final <= i_final_part;
        end
        if (i_ctrl.decode) begin
            r_base_x    <= w_base_x;
            r_base_y    <= w_base_y;
            r_tile_base <= {w_pal, 2'b00, w_idx} + w_flags;
            r_cols_m1   <= cols_m1(r_a0[15:14], r_a1[15:14]);
            r_rows_m1   <= rows_m1(r_a0[15:14], r_a1[15:14]);
            r_xm        <= r_a1[12] ? cols_m1(r_a0[15:14], r_a1[15:14]) : '0;
            r_ym        <= r_a1[13] ? rows_m1(r_a0[15:14], r_a1[15:14]) : '0;
            r_tx        <= '0;
            r_ty        <= '0;
        end else if (w_fire) begin
            if (r_tx == r_cols_m1) begin
                r_tx <= '0;
                r_ty <= r_ty + 1'b1;
            end else begin
                r_tx <= r_tx + 1'b1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pos_x  <= r_base_x + {4'b0, w_col, 3'b000};
            r_pos_y  <= r_base_y + {4'b0, w_row, 3'b000};
            r_tile   <= r_tile_base + {13'b0, r_tx} + {8'b0, r_ty, 5'b0};
            r_tvalid <= 1'b1;
            r_pend   <= w_last;
            r_fend   <= w_last && r_final;
        end else if (w_efire) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_tile   <= '0;
            r_tvalid <= 1'b0;
            r_pend   <= 1'b1;
            r_fend   <= r_final;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire || w_efire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = $signed(r_pos_x);
    assign o_pos_y       = $signed(r_pos_y);
    assign o_tile_number = r_tile;
    assign o_tile_valid  = r_tvalid;
    assign o_part_end    = r_pend;
    assign o_frame_end   = r_fend;

endmodule
